FILE: rtl/core/uart_status_keyword_spotter_macros.svh
// assertion helpers used by the checker file
`ifndef UART_STATUS_KEYWORD_SPOTTER_MACROS_SVH
`define UART_STATUS_KEYWORD_SPOTTER_MACROS_SVH

// property checked only outside reset
`define USKW_ASSERT(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);

// property checked on every edge, reset included
`define USKW_ASSERT_ALWAYS(lbl, ck, prop, msg) \
  lbl: assert property (@(posedge ck) prop) else $error(msg);

`endif

FILE: rtl/core/uskw_pkg.sv
`timescale 1ns / 1ps

package uskw_pkg;

  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 3;
  localparam int IDX_W    = 4;

  // network status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_NONE    = 3'd0,
    ST_UAP     = 3'd1,
    ST_CLOUD   = 3'd2,
    ST_LOCAL   = 3'd3,
    ST_OFFLINE = 3'd4,
    ST_UNPROV  = 3'd5
  } status_t;

  // keywords watched by the matchers
  typedef enum logic [2:0] {
    KW_ID,
    KW_UAP,
    KW_CLOUD,
    KW_LOCAL,
    KW_OFFLINE,
    KW_UNPROV
  } kw_t;

  localparam int LEN_ID      = 13;
  localparam int LEN_UAP     = 3;
  localparam int LEN_CLOUD   = 5;
  localparam int LEN_LOCAL   = 5;
  localparam int LEN_OFFLINE = 7;
  localparam int LEN_UNPROV  = 6;

  // first character sits in the top byte
  localparam logic [8*LEN_ID-1:0]      PAT_ID      = "uct id\":2692,";
  localparam logic [8*LEN_UAP-1:0]     PAT_UAP     = "uap";
  localparam logic [8*LEN_CLOUD-1:0]   PAT_CLOUD   = "cloud";
  localparam logic [8*LEN_LOCAL-1:0]   PAT_LOCAL   = "local";
  localparam logic [8*LEN_OFFLINE-1:0] PAT_OFFLINE = "offline";
  localparam logic [8*LEN_UNPROV-1:0]  PAT_UNPROV  = "unprov";

  function automatic int kw_len(kw_t kw);
    int n;
    case (kw)
      KW_ID:      n = LEN_ID;
      KW_UAP:     n = LEN_UAP;
      KW_CLOUD:   n = LEN_CLOUD;
      KW_LOCAL:   n = LEN_LOCAL;
      KW_OFFLINE: n = LEN_OFFLINE;
      KW_UNPROV:  n = LEN_UNPROV;
      default:    n = LEN_UAP;
    endcase
    return n;
  endfunction

  // expected character at a given position, zero past the end
  function automatic logic [BYTE_W-1:0] kw_char(kw_t kw, logic [IDX_W-1:0] idx);
    logic [BYTE_W-1:0] c;
    int pos;
    pos = int'(idx);
    c = '0;
    case (kw)
      KW_ID:      if (pos < LEN_ID)      c = PAT_ID[8*(LEN_ID-1-pos) +: 8];
      KW_UAP:     if (pos < LEN_UAP)     c = PAT_UAP[8*(LEN_UAP-1-pos) +: 8];
      KW_CLOUD:   if (pos < LEN_CLOUD)   c = PAT_CLOUD[8*(LEN_CLOUD-1-pos) +: 8];
      KW_LOCAL:   if (pos < LEN_LOCAL)   c = PAT_LOCAL[8*(LEN_LOCAL-1-pos) +: 8];
      KW_OFFLINE: if (pos < LEN_OFFLINE) c = PAT_OFFLINE[8*(LEN_OFFLINE-1-pos) +: 8];
      KW_UNPROV:  if (pos < LEN_UNPROV)  c = PAT_UNPROV[8*(LEN_UNPROV-1-pos) +: 8];
      default:    c = '0;
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/core/uskw_if.sv
`timescale 1ns / 1ps

// received byte channel
interface uskw_in_if;
  import uskw_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// status result channel
interface uskw_out_if;
  import uskw_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] net_status;
  logic                id_seen;

  modport source (output valid, output net_status, output id_seen, input ready);
  modport sink (input valid, input net_status, input id_seen, output ready);
endinterface

FILE: rtl/core/uskw_matcher.sv
`timescale 1ns / 1ps

module uskw_matcher #(
  parameter uskw_pkg::kw_t KW = uskw_pkg::KW_UAP
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic [uskw_pkg::BYTE_W-1:0] byte_in,
  output logic                      hit
);
  import uskw_pkg::*;

  localparam int LEN = kw_len(KW);
  localparam int PW  = $clog2(LEN);

  logic [PW-1:0] progress;
  logic [PW-1:0] progress_next;
  logic          match;
  logic          last;

  // compare against the next expected character
  always_comb begin
    match = (int'(progress) < LEN) && (byte_in == kw_char(KW, IDX_W'(progress)));
    last  = (progress == PW'(LEN - 1));
    hit   = match && last;
    if (match && !last) begin
      progress_next = progress + PW'(1);
    end else begin
      progress_next = '0;
    end
  end

  // progress count, updated once per transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      progress <= '0;
    end else if (en) begin
      progress <= progress_next;
    end
  end

endmodule

FILE: rtl/core/uart_status_keyword_spotter.sv
`timescale 1ns / 1ps

// UART status keyword spotter
// in_ch carries one received serial byte per transfer (rx_byte). out_ch
// returns exactly one result per byte: net_status, the sticky network
// status after that byte (none, uap, cloud, local, offline, unprov), and
// id_seen, high when the byte completes the product id text.
// Six literal matchers each keep a progress count; a byte that breaks a
// partial match clears the count and is not retried as a new start.
// A byte taken from in_ch is first registered in the input register, then
// matched and put in the result register once that register is free.
// Throughput: one byte per cycle while out_ch takes every result; the
// matchers are single-byte compares between the input register and the
// result register.
// Reset (rst, synchronous) clears all progress counts, the status to none
// and both valid flags.
// When out_ch stalls, the result holds; one more byte may wait in the input
// register, after which in_ch.ready drops until the result is taken.
module uart_status_keyword_spotter (
  input logic         clk,
  input logic         rst,
  uskw_in_if.sink     in_ch,
  uskw_out_if.source  out_ch
);
  import uskw_pkg::*;

  logic              s1_valid;
  logic [BYTE_W-1:0] s1_byte;
  logic              adv;

  logic hit_id, hit_uap, hit_cloud, hit_local, hit_offline, hit_unprov;

  status_t status_reg;
  status_t status_next;

  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic                out_id;

  // move a byte into the result register whenever that register frees
  assign adv         = s1_valid && (!out_valid || out_ch.ready);
  assign in_ch.ready = !s1_valid || adv;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_byte <= in_ch.rx_byte;
    end
  end

  // matchers
  uskw_matcher #(.KW(KW_ID)) u_id (
    .clk(clk), .rst(rst), .en(adv), .byte_in(s1_byte), .hit(hit_id)
  );
  uskw_matcher #(.KW(KW_UAP)) u_uap (
    .clk(clk), .rst(rst), .en(adv), .byte_in(s1_byte), .hit(hit_uap)
  );
  uskw_matcher #(.KW(KW_CLOUD)) u_cloud (
    .clk(clk), .rst(rst), .en(adv), .byte_in(s1_byte), .hit(hit_cloud)
  );
  uskw_matcher #(.KW(KW_LOCAL)) u_local (
    .clk(clk), .rst(rst), .en(adv), .byte_in(s1_byte), .hit(hit_local)
  );
  uskw_matcher #(.KW(KW_OFFLINE)) u_offline (
    .clk(clk), .rst(rst), .en(adv), .byte_in(s1_byte), .hit(hit_offline)
  );
  uskw_matcher #(.KW(KW_UNPROV)) u_unprov (
    .clk(clk), .rst(rst), .en(adv), .byte_in(s1_byte), .hit(hit_unprov)
  );

  // newest keyword wins, later matcher has priority
  always_comb begin
    status_next = status_reg;
    if (hit_uap)     status_next = ST_UAP;
    if (hit_cloud)   status_next = ST_CLOUD;
    if (hit_local)   status_next = ST_LOCAL;
    if (hit_offline) status_next = ST_OFFLINE;
    if (hit_unprov)  status_next = ST_UNPROV;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      status_reg <= ST_NONE;
    end else if (adv) begin
      status_reg <= status_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_status <= status_next;
      out_id     <= hit_id;
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.net_status = out_status;
  assign out_ch.id_seen    = out_id;

endmodule

FILE: rtl/core/uskw_checker.sv
`timescale 1ns / 1ps
`include "uart_status_keyword_spotter_macros.svh"

module uskw_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [uskw_pkg::STATUS_W-1:0] net_status,
  input logic                          id_seen
);
  import uskw_pkg::*;

  logic status_set;

  // remember that some keyword status has been delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      status_set <= 1'b0;
    end else if (out_valid && out_ready && (net_status != ST_NONE)) begin
      status_set <= 1'b1;
    end
  end

  `USKW_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !out_valid, "result valid right after reset")
  `USKW_ASSERT(a_stall_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(net_status) && $stable(id_seen), "stalled result changed")
  `USKW_ASSERT(a_free_ready, clk, rst, !out_valid |-> in_ready, "input stalled with empty result register")
  `USKW_ASSERT(a_sticky, clk, rst, out_valid && status_set |-> net_status != ST_NONE, "status fell back to none")

endmodule

bind uart_status_keyword_spotter uskw_checker u_chk (
  .clk(clk),
  .rst(rst),
  .in_ready(in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .net_status(out_ch.net_status),
  .id_seen(out_ch.id_seen)
);

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import uskw_pkg::*;

  localparam int N_WORDS     = 6;
  localparam int RAND_ITEMS  = 1450;
  localparam int QUIET_TAIL  = 150;
  localparam int STALL_LIMIT = 1000;
  localparam int DRAIN_WAIT  = 8;

  // one result of the spotter
  typedef struct packed {
    status_t net_status;
    logic    id_seen;
  } result_t;

  // directed stimulus row, golden result only where it is obvious
  typedef struct {
    logic [BYTE_W-1:0] b;
    logic              golden;
    result_t           gold;
  } row_t;

  logic clk;
  logic rst;

  uskw_in_if  in_ch ();
  uskw_out_if out_ch ();

  uart_status_keyword_spotter dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // keyword spotting model state
  string      word_text [N_WORDS];
  logic [3:0] match_pos [N_WORDS];
  status_t    spot_status;

  result_t status_due [$];
  row_t    dir_rows [$];
  int      mismatches;
  int      bytes_sent;
  logic    tail_quiet;
  logic    src_gaps;
  logic    sink_busy;
  int      stall_left;
  int      idle_cycles;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // advance every matcher by one byte and return the expected result
  function automatic result_t spot_byte(input logic [BYTE_W-1:0] b);
    result_t r;
    logic    done;
    int      k;
    int      n;
    r.id_seen = 1'b0;
    for (k = 0; k < N_WORDS; k++) begin
      done = 1'b0;
      n = word_text[k].len();
      if (match_pos[k] < n && b == word_text[k][match_pos[k]]) begin
        if (match_pos[k] + 1 == n) begin
          match_pos[k] = '0;
          done = 1'b1;
        end else begin
          match_pos[k] = match_pos[k] + 4'd1;
        end
      end else begin
        match_pos[k] = '0;
      end
      // later keywords in this order win the status
      if (done) begin
        case (kw_t'(k))
          KW_ID:      r.id_seen = 1'b1;
          KW_UAP:     spot_status = ST_UAP;
          KW_CLOUD:   spot_status = ST_CLOUD;
          KW_LOCAL:   spot_status = ST_LOCAL;
          KW_OFFLINE: spot_status = ST_OFFLINE;
          KW_UNPROV:  spot_status = ST_UNPROV;
          default:    ;
        endcase
      end
    end
    r.net_status = spot_status;
    return r;
  endfunction

  task automatic add_row(input logic [BYTE_W-1:0] b, input logic golden, input result_t gold);
    row_t row;
    row.b = b;
    row.golden = golden;
    row.gold = gold;
    dir_rows.push_back(row);
  endtask

  // text rows, golden result on the last character only
  task automatic add_text(input string s, input result_t last_res);
    int i;
    for (i = 0; i < s.len(); i++)
      add_row(s[i], (i == s.len() - 1), last_res);
  endtask

  // one byte transfer on the input channel, called at a falling edge
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic golden,
                           input result_t gold);
    result_t r;
    if (src_gaps && !tail_quiet && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    r = spot_byte(b);
    if (golden) r = gold;
    status_due.push_back(r);
    bytes_sent++;
    @(negedge clk);
  endtask

  // hold the sender until every result has come back
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (status_due.size() != 0) @(negedge clk);
  endtask

  // stimulus
  initial begin
    result_t none_r;
    int      i;
    int      k;
    int      n;
    int      pick;
    int      cut;
    logic    paused;
    rst           = 1'b1;
    in_ch.valid   = 1'b0;
    in_ch.rx_byte = '0;
    mismatches    = 0;
    bytes_sent    = 0;
    tail_quiet    = 1'b0;
    src_gaps      = 1'b1;
    paused        = 1'b0;
    spot_status   = ST_NONE;
    word_text[KW_ID]      = "uct id\":2692,";
    word_text[KW_UAP]     = "uap";
    word_text[KW_CLOUD]   = "cloud";
    word_text[KW_LOCAL]   = "local";
    word_text[KW_OFFLINE] = "offline";
    word_text[KW_UNPROV]  = "unprov";
    for (k = 0; k < N_WORDS; k++) match_pos[k] = '0;
    none_r.net_status = ST_NONE;
    none_r.id_seen    = 1'b0;

    // directed table: extremes, a broken start, overwrite and the id hit
    add_row(8'h00, 1'b1, none_r);
    add_row(8'hff, 1'b1, none_r);
    add_text("ccloud", none_r);
    add_text("uap", '{ST_UAP, 1'b0});
    add_text("uct id\":2692,", '{ST_UAP, 1'b1});
    add_text("local", '{ST_LOCAL, 1'b0});

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (i = 0; i < dir_rows.size(); i++)
      send_byte(dir_rows[i].b, dir_rows[i].golden, dir_rows[i].gold);
    drain_results();

    // random part: mostly whole keywords, some broken ones, some noise
    bytes_sent = 0;
    while (bytes_sent < RAND_ITEMS) begin
      tail_quiet = (bytes_sent >= RAND_ITEMS - QUIET_TAIL);
      if ($urandom_range(0, 7) == 0) src_gaps = !src_gaps;
      if (!paused && bytes_sent >= RAND_ITEMS / 2) begin
        drain_results();
        paused = 1'b1;
      end
      pick = $urandom_range(0, 99);
      k = $urandom_range(0, N_WORDS - 1);
      n = word_text[k].len();
      if (pick < 60) begin
        for (i = 0; i < n; i++) send_byte(word_text[k][i], 1'b0, none_r);
      end else if (pick < 78) begin
        // partial keyword, then a breaking byte, sometimes the rest
        cut = $urandom_range(1, n - 1);
        for (i = 0; i < cut; i++) send_byte(word_text[k][i], 1'b0, none_r);
        if ($urandom_range(0, 1) == 0)
          send_byte(word_text[k][0], 1'b0, none_r);
        else
          send_byte(BYTE_W'($urandom_range(0, 255)), 1'b0, none_r);
        if ($urandom_range(0, 1) == 0)
          for (i = cut; i < n; i++) send_byte(word_text[k][i], 1'b0, none_r);
      end else begin
        // noise: raw bytes or keyword letters out of order
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(0, 1) == 0) begin
            send_byte(BYTE_W'($urandom_range(0, 255)), 1'b0, none_r);
          end else begin
            k = $urandom_range(0, N_WORDS - 1);
            send_byte(word_text[k][$urandom_range(0, word_text[k].len() - 1)],
                      1'b0, none_r);
          end
        end
      end
    end

    drain_results();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // result side back-pressure in short bursts
  initial begin
    out_ch.ready = 1'b0;
    sink_busy    = 1'b1;
    stall_left   = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (sink_busy && !tail_quiet && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 3);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
      if ($urandom_range(0, 63) == 0) sink_busy = !sink_busy;
    end
  end

  // compare each result transfer with the oldest expectation
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (status_due.size() == 0) begin
        $display("%0t: unexpected result net_status %0d id_seen %0d",
                 $time, out_ch.net_status, out_ch.id_seen);
        mismatches++;
      end else begin
        want = status_due.pop_front();
        if (out_ch.net_status !== want.net_status) begin
          $display("%0t: net_status expected %0d got %0d",
                   $time, want.net_status, out_ch.net_status);
          mismatches++;
        end
        if (out_ch.id_seen !== want.id_seen) begin
          $display("%0t: id_seen expected %0d got %0d",
                   $time, want.id_seen, out_ch.id_seen);
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                 $time, idle_cycles, status_due.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

endmodule

FILE: uart_status_keyword_spotter.f
+incdir+rtl/core
rtl/core/uskw_pkg.sv
rtl/core/uskw_if.sv
rtl/core/uskw_matcher.sv
rtl/core/uart_status_keyword_spotter.sv
rtl/core/uskw_checker.sv
tb/sv/tb_top.sv
